>>> hw/rtl/okrt_pkg.sv
// ----------------------------------------------------------------------------
// okrt_pkg
// Types and codes shared by the ordered keyed record table: payload structs,
// command and status codes, controller states and the command/status bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package okrt_pkg;

  // Command codes carried in the input transaction
  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_SEARCH = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_DUMP   = 3'd4
  } okrt_cmd_e;

  // Status codes carried in the result transaction
  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } okrt_status_e;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_HIT,
    S_MISS,
    S_SHIFT,
    S_DONE,
    S_DUMP_RD,
    S_DUMP_OUT
  } okrt_state_e;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned ValueW = 32;

  // Input transaction
  typedef struct packed {
    logic [2:0]        command;
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
  } okrt_in_t;

  // Result transaction
  typedef struct packed {
    okrt_status_e      status;
    logic [KeyW-1:0]   found_key;
    logic [ValueW-1:0] found_value;
    logic              last;
  } okrt_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic         in_ld;       // latch the accepted input transaction
    logic         mem_ins;     // append the held record, bump the count
    logic         cnt_clr;     // empty the table
    logic         cnt_dec;     // drop one record from the count
    logic         idx_clr;     // restart the walk index
    logic         idx_inc;     // advance the walk index
    logic         idx_ld_next; // point the walk index past the hit
    logic         rd_en;       // read the record at the walk index
    logic         shift_wr;    // move the last read record down one place
    logic         out_ld;      // load the result register
    okrt_status_e out_status;
    logic         out_sel_rd;  // result carries the read record
    logic         out_last;
  } okrt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] op;        // held command code
    logic       full;
    logic       empty;
    logic       idx_lt_cnt;
    logic       idx_last;  // walk index is at the newest record
    logic       rd_vld;    // read data register holds a fresh record
    logic       hit;
    logic       miss;
    logic       out_free;  // result register can take a new result
  } okrt_stat_t;

endpackage

>>> hw/rtl/okrt_ctrl.sv
// ----------------------------------------------------------------------------
// okrt_ctrl
// Controller of the ordered keyed record table. Sequences each command
// through decode, table walk, compaction and result issue.
// ----------------------------------------------------------------------------
module okrt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  okrt_pkg::okrt_stat_t stat_i,
  output okrt_pkg::okrt_cmd_t  cmd_o
);

  okrt_pkg::okrt_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= okrt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      okrt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = okrt_pkg::S_EXEC;
        end
      end
      okrt_pkg::S_EXEC: begin
        case (stat_i.op)
          okrt_pkg::CMD_INSERT, okrt_pkg::CMD_CLEAR: begin
            if (stat_i.out_free) begin
              state_d = okrt_pkg::S_IDLE;
            end
          end
          okrt_pkg::CMD_SEARCH, okrt_pkg::CMD_DELETE: begin
            if (!stat_i.empty) begin
              state_d = okrt_pkg::S_SCAN;
            end else if (stat_i.out_free) begin
              state_d = okrt_pkg::S_IDLE;
            end
          end
          okrt_pkg::CMD_DUMP: begin
            if (!stat_i.empty) begin
              state_d = okrt_pkg::S_DUMP_RD;
            end else if (stat_i.out_free) begin
              state_d = okrt_pkg::S_IDLE;
            end
          end
          default: state_d = okrt_pkg::S_IDLE;
        endcase
      end
      okrt_pkg::S_SCAN: begin
        if (stat_i.hit) begin
          state_d = (stat_i.op == okrt_pkg::CMD_DELETE) ? okrt_pkg::S_SHIFT
                                                         : okrt_pkg::S_HIT;
        end else if (stat_i.miss) begin
          state_d = okrt_pkg::S_MISS;
        end
      end
      okrt_pkg::S_SHIFT: begin
        if (!stat_i.idx_lt_cnt && !stat_i.rd_vld) begin
          state_d = okrt_pkg::S_DONE;
        end
      end
      okrt_pkg::S_HIT, okrt_pkg::S_MISS, okrt_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          state_d = okrt_pkg::S_IDLE;
        end
      end
      okrt_pkg::S_DUMP_RD: state_d = okrt_pkg::S_DUMP_OUT;
      okrt_pkg::S_DUMP_OUT: begin
        if (stat_i.out_free) begin
          state_d = stat_i.idx_last ? okrt_pkg::S_IDLE : okrt_pkg::S_DUMP_RD;
        end
      end
      default: state_d = okrt_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = okrt_pkg::ST_DONE;
    cmd_o.out_last   = 1'b1;
    in_stall_o       = (state_q != okrt_pkg::S_IDLE);
    case (state_q)
      okrt_pkg::S_IDLE: begin
        cmd_o.in_ld = in_valid_i;
      end
      okrt_pkg::S_EXEC: begin
        case (stat_i.op)
          okrt_pkg::CMD_INSERT: begin
            cmd_o.out_ld     = stat_i.out_free;
            cmd_o.mem_ins    = stat_i.out_free && !stat_i.full;
            cmd_o.out_status = stat_i.full ? okrt_pkg::ST_FULL : okrt_pkg::ST_DONE;
          end
          okrt_pkg::CMD_CLEAR: begin
            cmd_o.out_ld     = stat_i.out_free;
            cmd_o.cnt_clr    = stat_i.out_free;
            cmd_o.out_status = stat_i.empty ? okrt_pkg::ST_EMPTY : okrt_pkg::ST_DONE;
          end
          okrt_pkg::CMD_SEARCH, okrt_pkg::CMD_DELETE, okrt_pkg::CMD_DUMP: begin
            cmd_o.idx_clr    = !stat_i.empty;
            cmd_o.out_ld     = stat_i.empty && stat_i.out_free;
            cmd_o.out_status = okrt_pkg::ST_EMPTY;
          end
          default: ;
        endcase
      end
      okrt_pkg::S_SCAN: begin
        // Stop issuing reads once the answer is known
        if (stat_i.hit) begin
          cmd_o.idx_ld_next = (stat_i.op == okrt_pkg::CMD_DELETE);
        end else if (!stat_i.miss && stat_i.idx_lt_cnt) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.idx_inc = 1'b1;
        end
      end
      okrt_pkg::S_SHIFT: begin
        cmd_o.shift_wr = stat_i.rd_vld;
        cmd_o.rd_en    = stat_i.idx_lt_cnt;
        cmd_o.idx_inc  = stat_i.idx_lt_cnt;
        cmd_o.cnt_dec  = !stat_i.idx_lt_cnt && !stat_i.rd_vld;
      end
      okrt_pkg::S_HIT: begin
        cmd_o.out_ld     = stat_i.out_free;
        cmd_o.out_status = okrt_pkg::ST_FOUND;
        cmd_o.out_sel_rd = 1'b1;
      end
      okrt_pkg::S_MISS: begin
        cmd_o.out_ld     = stat_i.out_free;
        cmd_o.out_status = okrt_pkg::ST_NOT_FOUND;
      end
      okrt_pkg::S_DONE: begin
        cmd_o.out_ld     = stat_i.out_free;
        cmd_o.out_status = okrt_pkg::ST_DONE;
      end
      okrt_pkg::S_DUMP_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      okrt_pkg::S_DUMP_OUT: begin
        cmd_o.out_ld     = stat_i.out_free;
        cmd_o.idx_inc    = stat_i.out_free;
        cmd_o.out_status = okrt_pkg::ST_FOUND;
        cmd_o.out_sel_rd = 1'b1;
        cmd_o.out_last   = stat_i.idx_last;
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/okrt_dp.sv
// ----------------------------------------------------------------------------
// okrt_dp
// Datapath of the ordered keyed record table: record memory, entry count,
// walk index, registered read port, key compare and result register.
// ----------------------------------------------------------------------------
module okrt_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  okrt_pkg::okrt_in_t   in_data_i,
  input  okrt_pkg::okrt_cmd_t  cmd_i,
  output okrt_pkg::okrt_stat_t stat_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output okrt_pkg::okrt_out_t  out_data_o
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Record memory
  logic [okrt_pkg::KeyW-1:0]   key_mem   [CAPACITY];
  logic [okrt_pkg::ValueW-1:0] value_mem [CAPACITY];

  okrt_pkg::okrt_in_t          item_q;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [CntW-1:0]             idx_q, idx_d;
  logic [CntW-1:0]             rd_idx_q;
  logic                        rd_vld_q;
  logic [okrt_pkg::KeyW-1:0]   rd_key_q;
  logic [okrt_pkg::ValueW-1:0] rd_value_q;
  okrt_pkg::okrt_out_t         out_q, out_d;
  logic                        out_vld_q, out_vld_d;
  logic                        out_free;
  logic                        mem_we;
  logic [AddrW-1:0]            mem_waddr;
  logic [okrt_pkg::KeyW-1:0]   mem_wkey;
  logic [okrt_pkg::ValueW-1:0] mem_wvalue;
  logic                        hit;

  // Hold the accepted transaction for the whole command
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_ld) begin
      item_q <= in_data_i;
    end
  end

  // Select the memory write: append at the tail or move a record down
  always_comb begin
    mem_we     = cmd_i.mem_ins || cmd_i.shift_wr;
    mem_waddr  = cnt_q[AddrW-1:0];
    mem_wkey   = item_q.key;
    mem_wvalue = item_q.value;
    if (cmd_i.shift_wr) begin
      mem_waddr  = rd_idx_q[AddrW-1:0] - AddrW'(1);
      mem_wkey   = rd_key_q;
      mem_wvalue = rd_value_q;
    end
  end

  // Memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[mem_waddr]   <= mem_wkey;
      value_mem[mem_waddr] <= mem_wvalue;
    end
    if (cmd_i.rd_en) begin
      rd_key_q   <= key_mem[idx_q[AddrW-1:0]];
      rd_value_q <= value_mem[idx_q[AddrW-1:0]];
      rd_idx_q   <= idx_q;
    end
  end

  // Count and walk index
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.mem_ins) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CntW'(1);
    end

    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_ld_next) begin
      idx_d = rd_idx_q + CntW'(1);
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      rd_vld_q <= cmd_i.rd_en;
    end
  end

  // Compare the read record against the held key
  assign hit = rd_vld_q && (rd_key_q == item_q.key);

  // Result register: free when empty or being taken this cycle
  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    if (cmd_i.out_ld) begin
      out_vld_d         = 1'b1;
      out_d.status      = cmd_i.out_status;
      out_d.last        = cmd_i.out_last;
      out_d.found_key   = cmd_i.out_sel_rd ? rd_key_q : '0;
      out_d.found_value = cmd_i.out_sel_rd ? rd_value_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Status to the controller
  always_comb begin
    stat_o            = '0;
    stat_o.op         = item_q.command;
    stat_o.full       = (cnt_q == CntW'(CAPACITY));
    stat_o.empty      = (cnt_q == '0);
    stat_o.idx_lt_cnt = (idx_q < cnt_q);
    stat_o.idx_last   = ((idx_q + CntW'(1)) == cnt_q);
    stat_o.rd_vld     = rd_vld_q;
    stat_o.hit        = hit;
    stat_o.miss       = rd_vld_q && !hit && ((rd_idx_q + CntW'(1)) == cnt_q);
    stat_o.out_free   = out_free;
  end

endmodule

>>> hw/rtl/ordered_keyed_record_table.sv
// ----------------------------------------------------------------------------
// ordered_keyed_record_table
// Fixed-capacity table of key/value records in insertion order with
// insert, search, delete-first-match, clear and dump commands.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------
//   in      | sink      | in_valid_i/in_stall_o  | in_data_i  (okrt_in_t)
//   out     | source    | out_valid_o/out_stall_i| out_data_o (okrt_out_t)
//
// One command is in flight at a time; the next is taken once the previous
// one has loaded its last result into the output register. Search and
// delete walk the held records, the walk reading one record per cycle
// through the single memory read port. Dump reads each record, then loads
// it as a result.
// Reset clears the count and control only; the memory needs no clearing.
// A stalled output holds the result and pauses the walk where a new result
// is due.
// ----------------------------------------------------------------------------
module ordered_keyed_record_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  okrt_pkg::okrt_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output okrt_pkg::okrt_out_t out_data_o
);

  okrt_pkg::okrt_cmd_t  cmd;
  okrt_pkg::okrt_stat_t stat;

  okrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  okrt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> dv/okrt_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okrt_table_checker
// Watches both channels of the ordered keyed record table and keeps its own
// copy of the records. Every input transaction taken by the block is turned
// into the results it should cause, and every result taken from the block is
// compared field by field against the oldest of those. Hands the number of
// mismatches and the number of results still due to the testbench top.
// ----------------------------------------------------------------------------
module okrt_table_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  okrt_pkg::okrt_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  okrt_pkg::okrt_out_t out_data_i,
  output int unsigned         fail_cnt_o,
  output int unsigned         pending_o
);

  logic [okrt_pkg::KeyW-1:0]   key_tbl [CAPACITY];
  logic [okrt_pkg::ValueW-1:0] val_tbl [CAPACITY];
  int unsigned                 rec_cnt;
  okrt_pkg::okrt_out_t         due_results_q[$];
  int unsigned                 new_fails;

  // Queue one expected result
  function automatic void push_result(okrt_pkg::okrt_status_e st,
                                      logic [okrt_pkg::KeyW-1:0] rkey,
                                      logic [okrt_pkg::ValueW-1:0] rval,
                                      logic rlast);
    okrt_pkg::okrt_out_t r;
    r.status      = st;
    r.found_key   = rkey;
    r.found_value = rval;
    r.last        = rlast;
    due_results_q.push_back(r);
  endfunction

  // Apply one command to the record copy and queue what it should report
  function automatic void apply_command(okrt_pkg::okrt_in_t t);
    int unsigned i;
    int unsigned hit;
    bit          found;
    found = 1'b0;
    hit   = 0;
    // unused codes leave the table alone and report nothing
    if (t.command > okrt_pkg::CMD_DUMP) return;
    if (t.command == okrt_pkg::CMD_INSERT) begin
      if (rec_cnt >= CAPACITY) begin
        push_result(okrt_pkg::ST_FULL, '0, '0, 1'b1);
      end else begin
        key_tbl[rec_cnt] = t.key;
        val_tbl[rec_cnt] = t.value;
        rec_cnt++;
        push_result(okrt_pkg::ST_DONE, '0, '0, 1'b1);
      end
      return;
    end
    if (rec_cnt == 0) begin
      push_result(okrt_pkg::ST_EMPTY, '0, '0, 1'b1);
      return;
    end
    // locate the oldest matching record
    for (i = 0; i < rec_cnt; i++) begin
      if (!found && key_tbl[i] == t.key) begin
        found = 1'b1;
        hit   = i;
      end
    end
    case (t.command)
      okrt_pkg::CMD_SEARCH: begin
        if (found) push_result(okrt_pkg::ST_FOUND, key_tbl[hit], val_tbl[hit], 1'b1);
        else push_result(okrt_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
      end
      okrt_pkg::CMD_DELETE: begin
        if (found) begin
          // close the gap, keeping insertion order
          for (i = hit; i + 1 < rec_cnt; i++) begin
            key_tbl[i] = key_tbl[i+1];
            val_tbl[i] = val_tbl[i+1];
          end
          rec_cnt--;
          push_result(okrt_pkg::ST_DONE, '0, '0, 1'b1);
        end else begin
          push_result(okrt_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
        end
      end
      okrt_pkg::CMD_CLEAR: begin
        rec_cnt = 0;
        push_result(okrt_pkg::ST_DONE, '0, '0, 1'b1);
      end
      default: begin
        for (i = 0; i < rec_cnt; i++) begin
          push_result(okrt_pkg::ST_FOUND, key_tbl[i], val_tbl[i], i + 1 == rec_cnt);
        end
      end
    endcase
  endfunction

  // Compare one taken result with the oldest expectation, return mismatches
  function automatic int unsigned check_result(okrt_pkg::okrt_out_t got);
    okrt_pkg::okrt_out_t want;
    int unsigned         errs;
    errs = 0;
    if (due_results_q.size() == 0) begin
      $error("unexpected result: status %0d found_key %h found_value %h last %b",
             got.status, got.found_key, got.found_value, got.last);
      return 1;
    end
    want = due_results_q.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errs++;
    end
    if (got.found_key !== want.found_key) begin
      $error("found_key: expected %h, got %h", want.found_key, got.found_key);
      errs++;
    end
    if (got.found_value !== want.found_value) begin
      $error("found_value: expected %h, got %h", want.found_value, got.found_value);
      errs++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %b, got %b", want.last, got.last);
      errs++;
    end
    return errs;
  endfunction

  // Check results before taking new commands: a result never belongs to a
  // command accepted on the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_cnt = 0;
      due_results_q.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      new_fails = 0;
      if (out_valid_i && !out_stall_i) new_fails = check_result(out_data_i);
      if (in_valid_i && !in_stall_i) apply_command(in_data_i);
      fail_cnt_o <= fail_cnt_o + new_fails;
      pending_o  <= due_results_q.size();
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the ordered keyed record table. Runs a directed pass over the
// empty table, duplicate keys, misses, deletes and unused command codes, then
// random episodes that fill the table past capacity, drain it and mix all
// commands over a small key pool so that hits and duplicates are common.
// Both channels idle at random; results are checked by okrt_table_checker.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned NUM_ITEMS    = 310;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned POOL_SIZE    = 4;

  // command codes the block ignores
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_ANY
  } mix_e;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  okrt_pkg::okrt_in_t  in_data   = '0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall = 1'b0;
  okrt_pkg::okrt_out_t out_data;
  int unsigned         fail_cnt;
  int unsigned         pending;
  int unsigned         cycle_cnt = 0;
  int unsigned         stall_left = 0;
  int unsigned         hold_n;
  int unsigned         n_sent = 0;
  bit                  no_idle = 1'b0;

  always #5 clk = ~clk;

  ordered_keyed_record_table #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  okrt_table_checker #(
    .CAPACITY(CAPACITY)
  ) i_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  // Stall the result channel for a random count after each transaction, and
  // now and then while no result is offered
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      hold_n = draw_wait();
      out_stall  <= (hold_n != 0);
      stall_left <= (hold_n != 0) ? hold_n - 1 : 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!out_valid && !no_idle && $urandom_range(0, 15) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[ordered_keyed_record_table] ERROR");
      $finish;
    end
  end

  // Offer one command after a random gap and hold it until taken
  task automatic send_cmd(logic [2:0] cmd, logic [okrt_pkg::KeyW-1:0] rec_key,
                          logic [okrt_pkg::ValueW-1:0] rec_value);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, key: rec_key, value: rec_value};
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  // Hold off new commands until every due result has come back
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [2:0] pick_cmd(mix_e mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 80) return okrt_pkg::CMD_INSERT;
        if (r < 88) return okrt_pkg::CMD_SEARCH;
        if (r < 94) return okrt_pkg::CMD_DELETE;
        if (r < 98) return okrt_pkg::CMD_DUMP;
        return okrt_pkg::CMD_CLEAR;
      end
      MIX_DRAIN: begin
        if (r < 10) return okrt_pkg::CMD_INSERT;
        if (r < 40) return okrt_pkg::CMD_SEARCH;
        if (r < 80) return okrt_pkg::CMD_DELETE;
        if (r < 92) return okrt_pkg::CMD_DUMP;
        if (r < 95) return okrt_pkg::CMD_CLEAR;
      end
      default: begin
        if (r < 40) return okrt_pkg::CMD_INSERT;
        if (r < 60) return okrt_pkg::CMD_SEARCH;
        if (r < 80) return okrt_pkg::CMD_DELETE;
        if (r < 92) return okrt_pkg::CMD_DUMP;
        if (r < 96) return okrt_pkg::CMD_CLEAR;
      end
    endcase
    // noise: a code the block ignores
    return 3'($urandom_range(CMD_RSVD5, CMD_RSVD7));
  endfunction

  initial begin
    logic [okrt_pkg::KeyW-1:0] key_pool [POOL_SIZE];
    logic [okrt_pkg::KeyW-1:0] rkey;
    logic [2:0]                cmd;
    mix_e                      mix;
    int unsigned               episode;
    int unsigned               ep_len;
    int unsigned               j;

    episode = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: every command but insert reports empty
    send_cmd(okrt_pkg::CMD_SEARCH, 16'h0000, 32'h0000_0000);
    send_cmd(okrt_pkg::CMD_DELETE, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(okrt_pkg::CMD_DUMP,   16'h0000, 32'h0000_0000);
    send_cmd(okrt_pkg::CMD_CLEAR,  16'hFFFF, 32'hFFFF_FFFF);
    // extremes and a duplicate key
    send_cmd(okrt_pkg::CMD_INSERT, 16'h0000, 32'h0000_0000);
    send_cmd(okrt_pkg::CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(okrt_pkg::CMD_INSERT, 16'h0000, 32'hA5A5_5A5A);
    send_cmd(okrt_pkg::CMD_SEARCH, 16'h0000, 32'hFFFF_FFFF);
    send_cmd(okrt_pkg::CMD_SEARCH, 16'h8001, 32'h0000_0000);
    send_cmd(okrt_pkg::CMD_DELETE, 16'h8001, 32'h0000_0000);
    send_cmd(okrt_pkg::CMD_DUMP,   16'h1234, 32'h1234_5678);
    // delete the oldest duplicate, the newer one must show up next
    send_cmd(okrt_pkg::CMD_DELETE, 16'h0000, 32'h0000_0000);
    send_cmd(okrt_pkg::CMD_SEARCH, 16'h0000, 32'h0000_0000);
    send_cmd(okrt_pkg::CMD_DUMP,   16'h0000, 32'h0000_0000);
    send_cmd(CMD_RSVD5,            16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_RSVD6,            16'h0000, 32'h0000_0000);
    send_cmd(CMD_RSVD7,            16'hAAAA, 32'h5555_AAAA);
    send_cmd(okrt_pkg::CMD_DELETE, 16'hFFFF, 32'h0000_0000);
    send_cmd(okrt_pkg::CMD_CLEAR,  16'h0000, 32'h0000_0000);
    send_cmd(okrt_pkg::CMD_DUMP,   16'h0000, 32'h0000_0000);
    wait_results();

    // random episodes; the first one fills the table past capacity
    while (n_sent < NUM_ITEMS) begin
      mix     = (episode == 0) ? MIX_FILL : mix_e'($urandom_range(MIX_FILL, MIX_ANY));
      ep_len  = (episode == 0) ? 40 : $urandom_range(20, 40);
      no_idle = ($urandom_range(0, 3) == 0);
      for (j = 0; j < POOL_SIZE; j++) key_pool[j] = 16'($urandom);
      if ($urandom_range(0, 2) == 0) begin
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
      end
      for (j = 0; j < ep_len && n_sent < NUM_ITEMS; j++) begin
        cmd  = pick_cmd(mix);
        rkey = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                            : key_pool[$urandom_range(0, POOL_SIZE - 1)];
        send_cmd(cmd, rkey, $urandom);
      end
      if ($urandom_range(0, 1) == 0) wait_results();
      episode++;
    end

    // drain, then let the block settle
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[ordered_keyed_record_table] OK");
    end else begin
      $display("[ordered_keyed_record_table] ERROR");
    end
    $finish;
  end

endmodule
